@@ rtl/ppts_pkg.sv @@
// shared constants, state encoding and widths for the perspective projection block
// no dependencies; imported by every module under rtl
package ppts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W         = 64;
    localparam int MUL_W         = 33;
    localparam int COORD_W       = 32;
    localparam int NEAR_W        = 31;
    localparam int SIZE_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int IDX_W         = 4;
    localparam int MAT_DEPTH     = 16;

    localparam logic [NEAR_W-1:0] NEAR_RESET   = 31'd6554;
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 16'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 16'd1080;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_PROJECT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_DIVX,
        ST_DIVX_WAIT,
        ST_DIVY,
        ST_DIVY_WAIT,
        ST_SX,
        ST_SX_ACC,
        ST_SY,
        ST_SY_ACC,
        ST_DONE
    } ppts_state_t;

endpackage

@@ rtl/perspective_project_to_screen.sv @@
// a visible point is transformed by the matrix, divided by w and mapped to the viewport
// before its result is raised; a point behind the near limit skips to a hidden result; a
// load item writes one matrix entry and gives no result
// the work runs on the shared multiplier (11 products) and two 32-step divides; in_stall
// is high while a point is in work
// reset: matrix cleared to zero, near limit 0.1, viewport 1920 by 1080, no result pending
module perspective_project_to_screen
    import ppts_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [IDX_W-1:0]            entry_index,
    input  logic signed [COORD_W-1:0]   entry_value,
    input  logic signed [COORD_W-1:0]   pos_x,
    input  logic signed [COORD_W-1:0]   pos_y,
    input  logic signed [COORD_W-1:0]   pos_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        visible,
    output logic signed [COORD_W-1:0]   screen_x,
    output logic signed [COORD_W-1:0]   screen_y,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [NEAR_W-1:0]           cfg_data
);

    localparam int PW = 2 * MUL_W;
    localparam logic signed [MUL_W-1:0] ONE = MUL_W'(1) << FRAC_BITS;

    ppts_state_t                state_reg;
    ppts_state_t                state_next;
    logic [1:0]                 row_reg;
    logic [1:0]                 col_reg;
    logic signed [COORD_W-1:0]  mat_reg [MAT_DEPTH];
    logic signed [COORD_W-1:0]  x_reg;
    logic signed [COORD_W-1:0]  y_reg;
    logic signed [COORD_W-1:0]  z_reg;
    logic signed [ACC_W-1:0]    cx_reg;
    logic signed [ACC_W-1:0]    cy_reg;
    logic signed [ACC_W-1:0]    cw_reg;
    logic signed [COORD_W-1:0]  nx_reg;
    logic signed [COORD_W-1:0]  ny_reg;
    logic signed [COORD_W-1:0]  sx_reg;
    logic signed [COORD_W-1:0]  sy_reg;
    logic                       vis_reg;
    logic [NEAR_W-1:0]          near_limit_reg;
    logic [SIZE_W-1:0]          screen_width_reg;
    logic [SIZE_W-1:0]          screen_height_reg;
    logic                       out_valid_reg;
    logic                       visible_reg;
    logic signed [COORD_W-1:0]  screen_x_reg;
    logic signed [COORD_W-1:0]  screen_y_reg;

    logic                       in_acc;
    logic                       out_load;
    logic                       mul_en;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PW-1:0]       prod;
    logic signed [ACC_W-1:0]    prod_term;
    logic signed [COORD_W-1:0]  scr_sat;
    logic                       div_start;
    logic                       div_done;
    logic signed [ACC_W-1:0]    div_num;
    logic signed [COORD_W-1:0]  div_quot;
    logic [1:0]                 row_code;
    logic signed [COORD_W-1:0]  mat_sel;
    logic signed [COORD_W-1:0]  pos_sel;
    logic                       cw_ok;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PW-1:0] v);
        if ((v[PW-1:COORD_W-1] == '0) || (v[PW-1:COORD_W-1] == '1))
            sat32 = v[COORD_W-1:0];
        else if (v[PW-1])
            sat32 = {1'b1, {(COORD_W-1){1'b0}}};
        else
            sat32 = {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    assign in_acc   = in_valid && !in_stall;
    assign row_code = (row_reg == 2'd2) ? 2'd3 : row_reg;
    assign mat_sel  = mat_reg[{row_code, col_reg}];
    assign cw_ok    = !(cw_reg < $signed({{(ACC_W-NEAR_W){1'b0}}, near_limit_reg}))
                      && (cw_reg != '0);
    assign prod_term = ACC_W'(prod >>> FRAC_BITS);
    assign scr_sat   = sat32(prod >>> 1);
    assign div_num   = (state_reg == ST_DIVX) ? cx_reg : cy_reg;

    always_comb
    begin
        case (col_reg)
            2'd0:    pos_sel = x_reg;
            2'd1:    pos_sel = y_reg;
            default: pos_sel = z_reg;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_SX:
            begin
                mul_a = MUL_W'(nx_reg) + ONE;
                mul_b = $signed({{(MUL_W-SIZE_W){1'b0}}, screen_width_reg});
            end
            ST_SY:
            begin
                mul_a = ONE - MUL_W'(ny_reg);
                mul_b = $signed({{(MUL_W-SIZE_W){1'b0}}, screen_height_reg});
            end
            default:
            begin
                mul_a = MUL_W'(pos_sel);
                mul_b = MUL_W'(mat_sel);
            end
        endcase
    end

    ppts_mul u_mul (
        .clk   (clk),
        .en    (mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    ppts_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cw_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        mul_en     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && (req_type == REQ_PROJECT))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mul_en     = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if ((row_reg == 2'd2) && (col_reg == 2'd2))
                    state_next = ST_CHECK;
                else
                    state_next = ST_MUL;
            end
            ST_CHECK:
            begin
                state_next = cw_ok ? ST_DIVX : ST_DONE;
            end
            ST_DIVX:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT:
            begin
                if (div_done)
                    state_next = ST_DIVY;
            end
            ST_DIVY:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT:
            begin
                if (div_done)
                    state_next = ST_SX;
            end
            ST_SX:
            begin
                mul_en     = 1'b1;
                state_next = ST_SX_ACC;
            end
            ST_SX_ACC:
            begin
                state_next = ST_SY;
            end
            ST_SY:
            begin
                mul_en     = 1'b1;
                state_next = ST_SY_ACC;
            end
            ST_SY_ACC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // matrix, configuration and output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_DEPTH; i++)
            begin
                mat_reg[i] <= '0;
            end
            near_limit_reg    <= NEAR_RESET;
            screen_width_reg  <= WIDTH_RESET;
            screen_height_reg <= HEIGHT_RESET;
            out_valid_reg     <= 1'b0;
            row_reg           <= '0;
            col_reg           <= '0;
        end
        else
        begin
            if (in_acc && (req_type == REQ_LOAD))
                mat_reg[entry_index] <= entry_value;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NEAR_LIMIT:    near_limit_reg    <= cfg_data;
                    CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SIZE_W-1:0];
                    default:           ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (in_acc)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (state_reg == ST_ACC)
            begin
                if (col_reg == 2'd2)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 2'd1;
                end
                else
                begin
                    col_reg <= col_reg + 2'd1;
                end
            end
        end
    end

    // point datapath
    always_ff @(posedge clk)
    begin
        if (in_acc && (req_type == REQ_PROJECT))
        begin
            x_reg  <= pos_x;
            y_reg  <= pos_y;
            z_reg  <= pos_z;
            cx_reg <= ACC_W'(mat_reg[3]);
            cy_reg <= ACC_W'(mat_reg[7]);
            cw_reg <= ACC_W'(mat_reg[15]);
        end
        if (state_reg == ST_ACC)
        begin
            case (row_reg)
                2'd0:    cx_reg <= cx_reg + prod_term;
                2'd1:    cy_reg <= cy_reg + prod_term;
                default: cw_reg <= cw_reg + prod_term;
            endcase
        end
        if (state_reg == ST_CHECK)
        begin
            vis_reg <= cw_ok;
            sx_reg  <= '0;
            sy_reg  <= '0;
        end
        if ((state_reg == ST_DIVX_WAIT) && div_done)
            nx_reg <= div_quot;
        if ((state_reg == ST_DIVY_WAIT) && div_done)
            ny_reg <= div_quot;
        if (state_reg == ST_SX_ACC)
            sx_reg <= scr_sat;
        if (state_reg == ST_SY_ACC)
            sy_reg <= scr_sat;
        if (out_load)
        begin
            visible_reg  <= vis_reg;
            screen_x_reg <= sx_reg;
            screen_y_reg <= sy_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_DIVX_WAIT) || (state_reg == ST_DIVY_WAIT)))
        else $error("divider finished outside a divide wait");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (req_type == REQ_LOAD) && !out_valid_reg) |=> !out_valid_reg)
        else $error("load transfer raised a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (req_type == REQ_PROJECT)) |=> in_stall)
        else $error("input taken while a point is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !visible_reg) |-> ((screen_x_reg == '0) && (screen_y_reg == '0)))
        else $error("hidden point with nonzero screen position");

endmodule

@@ rtl/ppts_mul.sv @@
// shared signed multiplier with a registered product
// depends on ppts_pkg for operand width
module ppts_mul
    import ppts_pkg::*;
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [MUL_W-1:0]     a,
    input  logic signed [MUL_W-1:0]     b,
    output logic signed [2*MUL_W-1:0]   p_reg
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

endmodule

@@ rtl/ppts_div.sv @@
// iterative restoring divider: num * 2^FRAC_BITS / den, truncated toward zero, saturated
// one quotient bit per cycle; depends on ppts_pkg
module ppts_div
    import ppts_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [ACC_W-1:0]     num,
    input  logic signed [ACC_W-1:0]     den,
    output logic                        done,
    output logic signed [COORD_W-1:0]   quot
);

    localparam int SH = COORD_W - FRAC_BITS;

    logic                   busy_reg;
    logic                   done_reg;
    logic [4:0]             cnt_reg;
    logic [ACC_W-1:0]       r_reg;
    logic [ACC_W-1:0]       r_next;
    logic [ACC_W-1:0]       d_reg;
    logic [COORD_W-1:0]     low_reg;
    logic [COORD_W-1:0]     q_reg;
    logic [COORD_W-1:0]     q_next;
    logic                   neg_reg;
    logic                   sat_reg;
    logic [ACC_W-1:0]       mag;
    logic [ACC_W-1:0]       mag_hi;
    logic [ACC_W:0]         trial;
    logic                   ge;

    assign mag    = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign mag_hi = mag >> SH;

    always_comb
    begin
        trial  = {r_reg, low_reg[COORD_W-1]};
        ge     = trial >= {1'b0, d_reg};
        r_next = ge ? ACC_W'(trial - {1'b0, d_reg}) : trial[ACC_W-1:0];
        q_next = {q_reg[COORD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= mag_hi;
            sat_reg <= mag_hi >= ACC_W'(den);
            low_reg <= {mag[SH-1:0], {FRAC_BITS{1'b0}}};
            d_reg   <= ACC_W'(den);
            neg_reg <= num[ACC_W-1];
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            r_reg   <= r_next;
            q_reg   <= q_next;
            low_reg <= {low_reg[COORD_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (sat_reg || (q_reg[COORD_W-1] && (q_reg[COORD_W-2:0] != '0)))
                quot = {1'b1, {(COORD_W-1){1'b0}}};
            else
                quot = $signed(-q_reg);
        end
        else
        begin
            if (sat_reg || q_reg[COORD_W-1])
                quot = {1'b0, {(COORD_W-1){1'b1}}};
            else
                quot = $signed(q_reg);
        end
    end

    assign done = done_reg;

endmodule
